FILE: rtl/udp_tick_frame_decoder_assert.svh
// ----------------------------------------------------------------------------
// udp tick frame decoder assertion macros
// concurrent checks clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UDP_TICK_FRAME_DECODER_ASSERT_SVH
`define UDP_TICK_FRAME_DECODER_ASSERT_SVH

// same-cycle implication
`define UTFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udp tick frame decoder check failed");

// next-cycle implication
`define UTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udp tick frame decoder check failed");

`endif

FILE: rtl/utfd_pkg.sv
// ----------------------------------------------------------------------------
// utfd_pkg
// types and fixed header constants for the udp tick frame decoder
// ----------------------------------------------------------------------------
package utfd_pkg;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK         = 3'd0;
    localparam status_t ST_SHORT      = 3'd1;
    localparam status_t ST_NOT_IPV4   = 3'd2;
    localparam status_t ST_BAD_IHL    = 3'd3;
    localparam status_t ST_NOT_UDP    = 3'd4;
    localparam status_t ST_UDP_SHORT  = 3'd5;
    localparam status_t ST_BAD_PAYLEN = 3'd6;
    localparam status_t ST_TRUNCATED  = 3'd7;

    localparam logic [6:0]  ETH_HDR_LEN      = 7'd14;
    localparam logic [6:0]  UDP_HDR_LEN      = 7'd8;
    localparam logic [5:0]  IPV4_MIN_HDR     = 6'd20;
    localparam logic [3:0]  TICK_PAYLOAD_LEN = 4'd14;
    localparam logic [15:0] MIN_FRAME_LEN    = 16'd42;
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [15:0] POS_ETYPE_HI     = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO     = 16'd13;
    localparam logic [15:0] POS_IHL          = 16'd14;
    localparam logic [15:0] POS_PROTO        = 16'd23;

endpackage

FILE: rtl/udp_tick_frame_decoder.sv
// ----------------------------------------------------------------------------
// udp_tick_frame_decoder
// extracts a 14-byte tick payload from an ethernet/ipv4/udp frame
// ----------------------------------------------------------------------------
// usage:
//   input channel carries one frame byte per beat (data_byte), frame_end on
//   the last byte, and frame_timestamp, which is sampled on a frame's first
//   byte. a beat is taken when in_valid is high and in_stall is low.
//   output channel gives one beat per frame, after the last byte: status,
//   the payload fields (zero unless status is ok) and the frame timestamp.
//   a beat is taken when out_valid is high and out_stall is low.
// timing:
//   one byte per cycle, sustained while in_stall is low. a byte is held in the
//   input register; header and payload capture plus the status checks then
//   run combinationally from it into the result register, which is loaded
//   when the last byte leaves the input register.
// reset:
//   clears the byte counter and empties both registers; the next byte starts
//   a new frame.
// stall:
//   a waiting result holds; bytes that are not last keep flowing. a second
//   last byte waits in the input register and raises in_stall until the
//   result register frees up.
// ----------------------------------------------------------------------------
`include "udp_tick_frame_decoder_assert.svh"

module udp_tick_frame_decoder
    import utfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_end,
    input  logic [63:0] frame_timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output status_t     status,
    output logic [31:0] tick_id,
    output logic [7:0]  tick_kind,
    output logic [7:0]  side,
    output logic [31:0] price_bits,
    output logic [31:0] quantity_bits,
    output logic [63:0] timestamp
);

    // input register
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_end_reg;
    logic [63:0] s1_ts_reg;

    // frame state
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] etype_reg, etype_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] udp_len_reg, udp_len_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] price_reg, price_next;
    logic [31:0] qty_reg, qty_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  side_reg, side_next;
    logic [63:0] stamp_reg, stamp_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg;
    logic [31:0] out_id_reg, out_price_reg, out_qty_reg;
    logic [7:0]  out_type_reg, out_side_reg;
    logic [63:0] out_stamp_reg;

    logic        in_take;
    logic        out_free;
    logic        s1_adv;
    logic        res_load;
    logic        first;
    logic        cap;
    logic [15:0] pos;
    logic [7:0]  b;
    logic [5:0]  base_ihl;
    logic [6:0]  udp_at;
    logic [6:0]  pay_at;
    logic [15:0] rel_full;
    logic        in_pay;
    logic [3:0]  rel;
    logic [1:0]  price_lane;
    logic [1:0]  qty_lane;
    logic [15:0] len;
    logic [15:0] hdr_end;
    logic [15:0] pay_end;
    status_t     st;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_end_reg || out_free);
    assign res_load = s1_adv && s1_end_reg;
    assign in_stall = s1_valid_reg && s1_end_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign pos   = cnt_reg;
    assign b     = s1_byte_reg;
    assign first = (cnt_reg == 16'd0);
    assign cap   = (cnt_reg != COUNT_MAX);

    assign base_ihl   = first ? 6'd0 : ihl_reg;
    assign udp_at     = ETH_HDR_LEN + {1'b0, base_ihl};
    assign pay_at     = udp_at + UDP_HDR_LEN;
    assign rel_full   = pos - {9'd0, pay_at};
    assign in_pay     = (pos > POS_IHL) && (pos >= {9'd0, pay_at})
                        && (rel_full < {12'd0, TICK_PAYLOAD_LEN});
    assign rel        = rel_full[3:0];
    assign price_lane = 2'(rel - 4'd6);
    assign qty_lane   = 2'(rel - 4'd10);

    always_comb
    begin
        etype_next   = first ? 16'd0 : etype_reg;
        ihl_next     = base_ihl;
        proto_next   = first ? 8'd0 : proto_reg;
        udp_len_next = first ? 16'd0 : udp_len_reg;
        id_next      = first ? 32'd0 : id_reg;
        price_next   = first ? 32'd0 : price_reg;
        qty_next     = first ? 32'd0 : qty_reg;
        type_next    = first ? 8'd0 : type_reg;
        side_next    = first ? 8'd0 : side_reg;
        stamp_next   = first ? s1_ts_reg : stamp_reg;
        cnt_next     = cap ? (cnt_reg + 16'd1) : cnt_reg;

        if (cap)
        begin
            if (pos == POS_ETYPE_HI)
            begin
                etype_next[15:8] = b;
            end
            if (pos == POS_ETYPE_LO)
            begin
                etype_next[7:0] = b;
            end
            if (pos == POS_IHL)
            begin
                ihl_next = {b[3:0], 2'b00};
            end
            if (pos == POS_PROTO)
            begin
                proto_next = b;
            end
            if (pos > POS_IHL)
            begin
                if (pos == {9'd0, udp_at} + 16'd4)
                begin
                    udp_len_next[15:8] = b;
                end
                if (pos == {9'd0, udp_at} + 16'd5)
                begin
                    udp_len_next[7:0] = b;
                end
            end
            if (in_pay)
            begin
                if (rel < 4'd4)
                begin
                    id_next[{rel[1:0], 3'b000} +: 8] = b;
                end
                else if (rel == 4'd4)
                begin
                    type_next = b;
                end
                else if (rel == 4'd5)
                begin
                    side_next = b;
                end
                else if (rel < 4'd10)
                begin
                    price_next[{price_lane, 3'b000} +: 8] = b;
                end
                else
                begin
                    qty_next[{qty_lane, 3'b000} +: 8] = b;
                end
            end
        end
    end

    // frame checks, first failure wins
    assign len     = cnt_next;
    assign hdr_end = 16'(ETH_HDR_LEN) + 16'(ihl_next) + 16'(UDP_HDR_LEN);
    assign pay_end = hdr_end + 16'(TICK_PAYLOAD_LEN);

    always_comb
    begin
        if (len < MIN_FRAME_LEN)
            st = ST_SHORT;
        else if (etype_next != ETHERTYPE_IPV4)
            st = ST_NOT_IPV4;
        else if ((ihl_next < IPV4_MIN_HDR) || (len < hdr_end))
            st = ST_BAD_IHL;
        else if (proto_next != PROTO_UDP)
            st = ST_NOT_UDP;
        else if (udp_len_next < 16'(UDP_HDR_LEN))
            st = ST_UDP_SHORT;
        else if ((udp_len_next - 16'(UDP_HDR_LEN)) != 16'(TICK_PAYLOAD_LEN))
            st = ST_BAD_PAYLEN;
        else if (pay_end > len)
            st = ST_TRUNCATED;
        else
            st = ST_OK;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 16'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                cnt_reg <= s1_end_reg ? 16'd0 : cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= frame_end;
            s1_ts_reg   <= frame_timestamp;
        end
        if (s1_adv)
        begin
            etype_reg   <= etype_next;
            ihl_reg     <= ihl_next;
            proto_reg   <= proto_next;
            udp_len_reg <= udp_len_next;
            id_reg      <= id_next;
            price_reg   <= price_next;
            qty_reg     <= qty_next;
            type_reg    <= type_next;
            side_reg    <= side_next;
            stamp_reg   <= stamp_next;
        end
        if (res_load)
        begin
            out_status_reg <= st;
            out_id_reg     <= (st == ST_OK) ? id_next : 32'd0;
            out_type_reg   <= (st == ST_OK) ? type_next : 8'd0;
            out_side_reg   <= (st == ST_OK) ? side_next : 8'd0;
            out_price_reg  <= (st == ST_OK) ? price_next : 32'd0;
            out_qty_reg    <= (st == ST_OK) ? qty_next : 32'd0;
            out_stamp_reg  <= stamp_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign tick_id       = out_id_reg;
    assign tick_kind     = out_type_reg;
    assign side          = out_side_reg;
    assign price_bits    = out_price_reg;
    assign quantity_bits = out_qty_reg;
    assign timestamp     = out_stamp_reg;

    `UTFD_ASSERT_NOW(a_fail_fields_zero, out_valid_reg && (out_status_reg != ST_OK),
        (out_id_reg == 32'd0) && (out_price_reg == 32'd0) && (out_qty_reg == 32'd0)
        && (out_type_reg == 8'd0) && (out_side_reg == 8'd0))
    `UTFD_ASSERT_NEXT(a_count_clears, res_load, cnt_reg == 16'd0)
    `UTFD_ASSERT_NEXT(a_no_spurious_result, s1_valid_reg && !s1_end_reg && !out_valid_reg,
        !out_valid_reg)
    `UTFD_ASSERT_NOW(a_stall_only_on_end, in_stall,
        s1_valid_reg && s1_end_reg && out_valid_reg)

endmodule
